@@ src/fbsc_pkg.sv @@
package fbsc_pkg;

  // block and half widths
  localparam int unsigned BLOCK_W     = 64;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned SRC_W       = HALF_W + KEY_W;
  localparam int unsigned SRC_IDX_W   = $clog2(SRC_W);
  localparam int unsigned WIRE_IDX_W  = $clog2(HALF_W);
  localparam int unsigned SEL_ROWS    = 16;
  localparam int unsigned ROUNDS_DEF  = 16;
  localparam int unsigned S_TDATA_W   = BLOCK_W + KEY_W;
  localparam int unsigned M_TDATA_W   = BLOCK_W;

  // the two halves carried from round to round
  typedef struct packed {
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } half_pair_t;

  // selection rows, bit q set means bit q of {left, key} is gathered;
  // higher source bits end up higher in the gathered word
  localparam logic [SRC_W-1:0] SEL_TAB [SEL_ROWS] = '{
    64'b01000001_01010011_10111011_00111100_01001010_11100011_00101100_11011100,
    64'b00011010_01001100_00000111_10001101_01111100_10111111_00111010_10110000,
    64'b10101101_11001010_01101001_11000100_01010101_01000010_00011010_11111101,
    64'b11101111_11000010_10010000_11101010_00111100_10011000_11100101_01000011,
    64'b10101001_01110110_00101011_00111000_10100111_00110110_10000110_01111000,
    64'b10101011_01101111_11100000_01011100_00101001_01110011_00101000_10001011,
    64'b00011010_01000100_00100110_01010110_11000101_11111011_00100101_01110111,
    64'b11100110_00001011_01100010_10111001_00111010_10110011_00011101_00010110,
    64'b11100101_00101101_10010010_10001000_01101101_11001000_01100111_10111100,
    64'b10111001_00010011_01110010_00111010_11010111_01100110_10100110_11000000,
    64'b10100011_10111101_01000010_10000101_10010110_10110001_01100100_10011111,
    64'b11100000_11011100_01110101_10000011_00001010_01111110_01001100_00110111,
    64'b10010100_01110001_00010100_10111101_10001101_11100111_11010100_01001001,
    64'b10000110_00111111_00100011_10001010_00010011_01111101_01011100_11000101,
    64'b11010101_00010011_00011111_10100101_00101011_00101000_01101000_11111001,
    64'b10000111_10010100_10111111_11001111_00100001_10011111_10000010_00010100
  };

  // wiring table, gathered bit index for each round-word bit, msb row first
  localparam logic [WIRE_IDX_W-1:0] WIRE_COL [HALF_W] = '{
    5'd15, 5'd13, 5'd30, 5'd27, 5'd0,  5'd14, 5'd28, 5'd8,
    5'd31, 5'd13, 5'd19, 5'd20, 5'd27, 5'd19, 5'd14, 5'd29,
    5'd22, 5'd16, 5'd30, 5'd11, 5'd20, 5'd25, 5'd19, 5'd17,
    5'd24, 5'd5,  5'd24, 5'd13, 5'd20, 5'd11, 5'd0,  5'd22
  };

  // source bit feeding wiring row 'row' in round 'rnd': {hit, position};
  // no hit when the row picks a gathered bit beyond the gathered count
  function automatic logic [SRC_IDX_W:0] src_pos(int unsigned rnd, int unsigned row);
    logic [SRC_W-1:0] mask;
    int unsigned      want;
    int unsigned      seen;
    logic [SRC_IDX_W:0] res;
    mask = SEL_TAB[rnd % SEL_ROWS];
    want = int'(WIRE_COL[row]);
    seen = 0;
    res  = '0;
    for (int q = 0; q < SRC_W; q++) begin
      if (mask[q]) begin
        if (seen == want) begin
          res = {1'b1, SRC_IDX_W'(q)};
        end
        seen++;
      end
    end
    return res;
  endfunction

endpackage

@@ src/fbsc_round.sv @@
module fbsc_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  fbsc_pkg::half_pair_t        pair_i,
  input  logic [fbsc_pkg::KEY_W-1:0]  key_i,
  output fbsc_pkg::half_pair_t        pair_o
);
  import fbsc_pkg::*;

  logic [SRC_W-1:0]  src;
  logic [HALF_W-1:0] mix;

  // gather source: left half above key
  assign src = {pair_i.left, key_i};

  // fixed wiring from source bits to the round word, msb row first
  for (genvar i = 0; i < HALF_W; i++) begin : g_wire
    localparam logic [SRC_IDX_W:0] Pos = src_pos(RoundIdx, i);
    if (Pos[SRC_IDX_W]) begin : g_hit
      assign mix[HALF_W-1-i] = src[Pos[SRC_IDX_W-1:0]];
    end else begin : g_miss
      assign mix[HALF_W-1-i] = 1'b0;
    end
  end

  // feistel swap
  assign pair_o.left  = pair_i.right;
  assign pair_o.right = mix ^ pair_i.right;

endmodule

@@ src/fbsc_core.sv @@
module fbsc_core #(
  parameter int unsigned RoundCount = fbsc_pkg::ROUNDS_DEF
) (
  input  logic [fbsc_pkg::BLOCK_W-1:0] plaintext_i,
  input  logic [fbsc_pkg::KEY_W-1:0]   key_i,
  output logic [fbsc_pkg::BLOCK_W-1:0] ciphertext_o
);
  import fbsc_pkg::*;

  half_pair_t chain [RoundCount+1];

  // left half is the upper word of the block
  assign chain[0].left  = plaintext_i[BLOCK_W-1:HALF_W];
  assign chain[0].right = plaintext_i[HALF_W-1:0];

  // unrolled round chain
  for (genvar r = 0; r < RoundCount; r++) begin : g_round
    fbsc_round #(
      .RoundIdx(r)
    ) u_round (
      .pair_i(chain[r]),
      .key_i (key_i),
      .pair_o(chain[r+1])
    );
  end

  assign ciphertext_o = {chain[RoundCount].left, chain[RoundCount].right};

endmodule

@@ src/feistel_bit_select_cipher_top.sv @@
// channel   dir  tdata fields (lsb first)                     handshake
// s_axis    in   plaintext[63:0], cipher_key[95:64]           tvalid/tready
// m_axis    out  ciphertext[63:0]                             tvalid/tready
//
// two register stages: input register, then all rounds combinationally into the
// result register; m_axis tvalid rises when the item moves into the result stage
// one item per cycle sustained unless m_axis stalls; the unrolled round chain depth sets the period
// rst_ni clears both valid flags only; payload registers are not reset
// an m_axis stall holds the result and lets one more item fill the input stage
module feistel_bit_select_cipher_top #(
  parameter int unsigned RoundCount = fbsc_pkg::ROUNDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [fbsc_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // plaintext, cipher_key
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [fbsc_pkg::M_TDATA_W-1:0]  m_axis_tdata_o   // ciphertext
);
  import fbsc_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [BLOCK_W-1:0]  in_block_q, in_block_d;
  logic [KEY_W-1:0]    in_key_q, in_key_d;
  logic                out_valid_q, out_valid_d;
  logic [BLOCK_W-1:0]  out_data_q, out_data_d;
  logic                s1_ready;
  logic                s2_ready;
  logic [BLOCK_W-1:0]  cipher;

  // stage readiness
  assign s2_ready = !out_valid_q || m_axis_tready_i;
  assign s1_ready = !in_valid_q || s2_ready;

  // input stage next state
  always_comb begin
    in_valid_d = in_valid_q;
    in_block_d = in_block_q;
    in_key_d   = in_key_q;
    if (s1_ready) begin
      in_valid_d = s_axis_tvalid_i;
      in_block_d = s_axis_tdata_i[BLOCK_W-1:0];
      in_key_d   = s_axis_tdata_i[S_TDATA_W-1:BLOCK_W];
    end
  end

  // cipher rounds
  fbsc_core #(
    .RoundCount(RoundCount)
  ) u_core (
    .plaintext_i (in_block_q),
    .key_i       (in_key_q),
    .ciphertext_o(cipher)
  );

  // result stage next state
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s2_ready) begin
      out_valid_d = in_valid_q;
      out_data_d  = cipher;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_block_q <= in_block_d;
    in_key_q   <= in_key_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = s1_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // an accepted item sits in the input stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> in_valid_q)
    else $error("accepted item not held in input stage");

  // an empty input stage never back-pressures
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input stage empty but not ready");

  // a moving item from the input stage becomes a result
  a_move_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && s2_ready) |=> m_axis_tvalid_o)
    else $error("item lost between stages");

  // a result appears only from a full input stage
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without item");

endmodule
